### hdl/rvdec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RV32IM instruction decoder.
package rvdec_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned RegIdxWidth = 5;

  // Major opcodes, instruction bits 6..0
  localparam logic [6:0] OpRegAlu = 7'b0110011;
  localparam logic [6:0] OpImmAlu = 7'b0010011;
  localparam logic [6:0] OpLoad   = 7'b0000011;
  localparam logic [6:0] OpJalr   = 7'b1100111;
  localparam logic [6:0] OpStore  = 7'b0100011;
  localparam logic [6:0] OpBranch = 7'b1100011;
  localparam logic [6:0] OpJal    = 7'b1101111;
  localparam logic [6:0] OpAuipc  = 7'b0010111;
  localparam logic [6:0] OpLui    = 7'b0110111;

  // funct7 that selects the multiply/divide extension
  localparam logic [6:0] Funct7MulDiv = 7'b0000001;
  localparam logic [6:0] Funct7Zero   = 7'b0000000;
  localparam logic [6:0] Funct7Alt    = 7'b0100000;

  // funct3 codes of the immediate shifts
  localparam logic [2:0] Funct3Sll = 3'b001;
  localparam logic [2:0] Funct3Srx = 3'b101;

  typedef enum logic [3:0] {
    FMT_R     = 4'd0,
    FMT_M     = 4'd1,
    FMT_I     = 4'd2,
    FMT_SHIFT = 4'd3,
    FMT_S     = 4'd4,
    FMT_B     = 4'd5,
    FMT_J     = 4'd6,
    FMT_U     = 4'd7,
    FMT_BAD   = 4'd8
  } fmt_class_t;

  typedef struct packed {
    fmt_class_t             format_class;
    logic [6:0]             major_opcode;
    logic [2:0]             minor_function;
    logic [6:0]             upper_function;
    logic [RegIdxWidth-1:0] dest_reg;
    logic [RegIdxWidth-1:0] src_reg_a;
    logic [RegIdxWidth-1:0] src_reg_b;
    logic [InstrWidth-1:0]  immediate;
    logic                   alloc_dest;
  } dec_fields_t;

endpackage

### hdl/rv32im_instruction_decoder.sv
`timescale 1ns / 1ps
// Top level of the RV32IM instruction decoder: input register, decode, result register.
//
//   channel   direction  handshake               payload
//   in_       request    in_valid / in_ready     in_instruction (32 bits)
//   out_      result     out_valid / out_ready   decoded fields, one result per request
//
// A request is decoded while it sits in the input register; the result register then
// takes it and out_valid rises, and the result can leave from there. With out_ready
// held high a new request is accepted every cycle.
// Reset (rst_n low, synchronous) clears both valid flags only.
// A stalled result holds in the result register; the input register still takes one
// more request, and in_ready drops only when both registers are full.
module rv32im_instruction_decoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [rvdec_pkg::InstrWidth-1:0]      in_instruction,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [3:0]                            out_format_class,
  output logic [6:0]                            out_major_opcode,
  output logic [2:0]                            out_minor_function,
  output logic [6:0]                            out_upper_function,
  output logic [rvdec_pkg::RegIdxWidth-1:0]     out_dest_reg,
  output logic [rvdec_pkg::RegIdxWidth-1:0]     out_src_reg_a,
  output logic [rvdec_pkg::RegIdxWidth-1:0]     out_src_reg_b,
  output logic signed [rvdec_pkg::InstrWidth-1:0] out_immediate,
  output logic                                  out_alloc_dest
);

  logic                             in_vld_r;
  logic                             in_vld_nxt;
  logic [rvdec_pkg::InstrWidth-1:0] instr_r;
  logic                             res_vld_r;
  logic                             res_vld_nxt;
  rvdec_pkg::dec_fields_t           res_r;
  rvdec_pkg::dec_fields_t           dec_fields;
  logic                             res_load;
  logic                             in_load;

  // Result register can take a new entry when empty or when its entry leaves now
  assign res_load = !res_vld_r || out_ready;
  // Input register advances into the result register whenever that one can load
  assign in_ready = !in_vld_r || res_load;
  assign in_load  = in_valid && in_ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ready) begin
      in_vld_nxt = in_valid;
    end
    res_vld_nxt = res_vld_r;
    if (res_load) begin
      res_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // Payload registers: capture only on a move, hold otherwise
  always_ff @(posedge clk) begin
    if (in_load) begin
      instr_r <= in_instruction;
    end
    if (res_load && in_vld_r) begin
      res_r <= dec_fields;
    end
  end

  rvdec_decode u_decode (
    .instr  (instr_r),
    .fields (dec_fields)
  );

  assign out_valid          = res_vld_r;
  assign out_format_class   = res_r.format_class;
  assign out_major_opcode   = res_r.major_opcode;
  assign out_minor_function = res_r.minor_function;
  assign out_upper_function = res_r.upper_function;
  assign out_dest_reg       = res_r.dest_reg;
  assign out_src_reg_a      = res_r.src_reg_a;
  assign out_src_reg_b      = res_r.src_reg_b;
  assign out_immediate      = res_r.immediate;
  assign out_alloc_dest     = res_r.alloc_dest;

endmodule

### hdl/rvdec_decode.sv
`timescale 1ns / 1ps
// Combinational field extraction and format classification of one instruction word.
module rvdec_decode (
  input  logic [rvdec_pkg::InstrWidth-1:0] instr,
  output rvdec_pkg::dec_fields_t           fields
);

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic        is_shift;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] imm_sh;

  assign op = instr[6:0];
  assign f3 = instr[14:12];
  assign f7 = instr[31:25];

  // SLLI, SRLI and SRAI encodings only; other funct7 values fall back to I
  assign is_shift = ((f3 == rvdec_pkg::Funct3Sll) && (f7 == rvdec_pkg::Funct7Zero))
                 || ((f3 == rvdec_pkg::Funct3Srx) && (f7 == rvdec_pkg::Funct7Zero))
                 || ((f3 == rvdec_pkg::Funct3Srx) && (f7 == rvdec_pkg::Funct7Alt));

  assign imm_i  = {{20{instr[31]}}, instr[31:20]};
  assign imm_s  = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign imm_b  = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign imm_j  = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign imm_u  = {instr[31:12], 12'h000};
  assign imm_sh = {27'd0, instr[24:20]};

  always_comb begin
    fields                = '0;
    fields.major_opcode   = op;
    fields.minor_function = f3;
    fields.dest_reg       = instr[11:7];
    fields.src_reg_a      = instr[19:15];
    fields.src_reg_b      = instr[24:20];
    fields.format_class   = rvdec_pkg::FMT_BAD;
    case (op)
      rvdec_pkg::OpRegAlu: begin
        fields.upper_function = f7;
        fields.format_class   = (f7 == rvdec_pkg::Funct7MulDiv) ? rvdec_pkg::FMT_M
                                                                 : rvdec_pkg::FMT_R;
      end
      rvdec_pkg::OpImmAlu: begin
        fields.upper_function = f7;
        if (is_shift) begin
          fields.format_class = rvdec_pkg::FMT_SHIFT;
          fields.immediate    = imm_sh;
        end else begin
          fields.format_class = rvdec_pkg::FMT_I;
          fields.immediate    = imm_i;
        end
      end
      rvdec_pkg::OpLoad, rvdec_pkg::OpJalr: begin
        fields.format_class = rvdec_pkg::FMT_I;
        fields.immediate    = imm_i;
      end
      rvdec_pkg::OpStore: begin
        fields.format_class = rvdec_pkg::FMT_S;
        fields.immediate    = imm_s;
      end
      rvdec_pkg::OpBranch: begin
        fields.format_class = rvdec_pkg::FMT_B;
        fields.immediate    = imm_b;
      end
      rvdec_pkg::OpJal: begin
        fields.format_class = rvdec_pkg::FMT_J;
        fields.immediate    = imm_j;
      end
      rvdec_pkg::OpAuipc, rvdec_pkg::OpLui: begin
        fields.format_class = rvdec_pkg::FMT_U;
        fields.immediate    = imm_u;
      end
      default: begin
        fields.format_class = rvdec_pkg::FMT_BAD;
      end
    endcase
    fields.alloc_dest = (fields.format_class != rvdec_pkg::FMT_S)
                     && (fields.format_class != rvdec_pkg::FMT_B)
                     && (instr[11:7] != '0);
  end

endmodule

### tb/sv/rvdec_decode_checker.sv
`timescale 1ns / 1ps
// Decode predictor and result checker for the RV32IM instruction decoder.
module rvdec_decode_checker
  import rvdec_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [InstrWidth-1:0]         in_instruction,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [3:0]                    out_format_class,
  input  logic [6:0]                    out_major_opcode,
  input  logic [2:0]                    out_minor_function,
  input  logic [6:0]                    out_upper_function,
  input  logic [RegIdxWidth-1:0]        out_dest_reg,
  input  logic [RegIdxWidth-1:0]        out_src_reg_a,
  input  logic [RegIdxWidth-1:0]        out_src_reg_b,
  input  logic signed [InstrWidth-1:0]  out_immediate,
  input  logic                          out_alloc_dest,
  output int                            mismatch_count,
  output int                            pending_count
);

  dec_fields_t expected_decodes[$];

  // Slice one instruction word into its decoded fields.
  function automatic dec_fields_t decode_word(input logic [InstrWidth-1:0] w);
    dec_fields_t d;
    logic [6:0]  f7;
    logic [2:0]  f3;
    d = '0;
    f7 = w[31:25];
    f3 = w[14:12];
    d.format_class   = FMT_BAD;
    d.major_opcode   = w[6:0];
    d.minor_function = f3;
    d.dest_reg       = w[11:7];
    d.src_reg_a      = w[19:15];
    d.src_reg_b      = w[24:20];
    case (w[6:0])
      OpRegAlu: begin
        d.upper_function = f7;
        d.format_class = (f7 == Funct7MulDiv) ? FMT_M : FMT_R;
      end
      OpImmAlu: begin
        d.upper_function = f7;
        if ((f3 == Funct3Sll && f7 == Funct7Zero) ||
            (f3 == Funct3Srx && (f7 == Funct7Zero || f7 == Funct7Alt))) begin
          d.format_class = FMT_SHIFT;
          d.immediate = {27'b0, w[24:20]};
        end else begin
          d.format_class = FMT_I;
          d.immediate = {{20{w[31]}}, w[31:20]};
        end
      end
      OpLoad, OpJalr: begin
        d.format_class = FMT_I;
        d.immediate = {{20{w[31]}}, w[31:20]};
      end
      OpStore: begin
        d.format_class = FMT_S;
        d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      OpBranch: begin
        d.format_class = FMT_B;
        d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      end
      OpJal: begin
        d.format_class = FMT_J;
        d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      OpAuipc, OpLui: begin
        d.format_class = FMT_U;
        d.immediate = {w[31:12], 12'b0};
      end
      default: ;
    endcase
    d.alloc_dest = (d.format_class != FMT_S) && (d.format_class != FMT_B) &&
                   (d.dest_reg != '0);
    return d;
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    dec_fields_t got;
    dec_fields_t want;
    if (rst_n) begin
      if (in_valid && in_ready) expected_decodes.push_back(decode_word(in_instruction));
      if (out_valid && out_ready) begin
        got = '{format_class: fmt_class_t'(out_format_class),
                major_opcode: out_major_opcode, minor_function: out_minor_function,
                upper_function: out_upper_function, dest_reg: out_dest_reg,
                src_reg_a: out_src_reg_a, src_reg_b: out_src_reg_b,
                immediate: out_immediate, alloc_dest: out_alloc_dest};
        if (expected_decodes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: decoded result with no request pending: %p", $realtime, got);
        end else begin
          want = expected_decodes.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: decode differs", $realtime);
              $display("  expected cls=%0d op=%h f3=%h f7=%h rd=%0d rs1=%0d rs2=%0d imm=%h al=%b",
                       want.format_class, want.major_opcode, want.minor_function,
                       want.upper_function, want.dest_reg, want.src_reg_a,
                       want.src_reg_b, want.immediate, want.alloc_dest);
              $display("  actual   cls=%0d op=%h f3=%h f7=%h rd=%0d rs1=%0d rs2=%0d imm=%h al=%b",
                       got.format_class, got.major_opcode, got.minor_function,
                       got.upper_function, got.dest_reg, got.src_reg_a,
                       got.src_reg_b, got.immediate, got.alloc_dest);
            end
          end
        end
      end
      pending_count = expected_decodes.size();
    end
  end

endmodule

### tb/sv/rv32im_instruction_decoder_tb.sv
`timescale 1ns / 1ps
// Testbench top: request stimulus, result back-pressure and verdict for the decoder.
module rv32im_instruction_decoder_tb;
  import rvdec_pkg::*;

  // Random requests after the directed list; roughly the run length.
  localparam int RandomRequests = 500;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [InstrWidth-1:0]         in_instruction = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [3:0]                    out_format_class;
  logic [6:0]                    out_major_opcode;
  logic [2:0]                    out_minor_function;
  logic [6:0]                    out_upper_function;
  logic [RegIdxWidth-1:0]        out_dest_reg;
  logic [RegIdxWidth-1:0]        out_src_reg_a;
  logic [RegIdxWidth-1:0]        out_src_reg_b;
  logic signed [InstrWidth-1:0]  out_immediate;
  logic                          out_alloc_dest;

  int mismatch_count;
  int pending_count;

  // Opcodes that decode to a real format class; random requests mostly draw from these.
  localparam logic [6:0] KnownOps [9] = '{OpRegAlu, OpImmAlu, OpLoad, OpJalr, OpStore,
                                          OpBranch, OpJal, OpAuipc, OpLui};

  // Directed requests: field extremes, every class, and the corner encodings.
  localparam logic [31:0] DirectedWords [24] = '{
    32'h0000_0033,  // R add, all register fields zero
    32'hFFFF_FFB3,  // R with funct7 all ones, rd/rs1/rs2 all ones
    32'h4000_00B3,  // R with the alternate funct7 (sub)
    32'h03FF_FFB3,  // M: funct7 of one, everything else ones
    32'h0200_0033,  // M with rd zero: no destination allocated
    32'hFFF0_0093,  // I addi with an all-ones immediate, which is -1
    32'h7FF0_0013,  // I addi with the largest positive immediate, rd zero
    32'h01F0_1093,  // slli with shamt 31
    32'h0000_5013,  // srli with shamt 0
    32'h41F0_5F93,  // srai
    32'h4000_1013,  // odd shift: funct3 1 with funct7 0100000 falls back to I
    32'hFE00_5013,  // odd shift: funct3 5 with funct7 all ones falls back to I
    32'h0210_1013,  // odd shift: funct3 1 with funct7 one falls back to I
    32'hFFFF_F003,  // load, negative offset
    32'h0000_8067,  // jalr, rd zero
    32'hFFFF_FFA3,  // store, all immediate bits set
    32'h0000_0023,  // store, immediate zero
    32'hFFFF_FFE3,  // branch, all immediate bits set
    32'h0000_0F63,  // branch, only the low offset bits
    32'h8000_00EF,  // jal, sign bit only
    32'h7FFF_FFEF,  // jal, all but the sign bit
    32'hFFFF_F0B7,  // lui, upper bits all ones
    32'h0000_0017,  // auipc, zero
    32'hFFFF_FFFF   // unknown opcode, rd nonzero still allocates
  };

  rv32im_instruction_decoder i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_instruction     (in_instruction),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_format_class   (out_format_class),
    .out_major_opcode   (out_major_opcode),
    .out_minor_function (out_minor_function),
    .out_upper_function (out_upper_function),
    .out_dest_reg       (out_dest_reg),
    .out_src_reg_a      (out_src_reg_a),
    .out_src_reg_b      (out_src_reg_b),
    .out_immediate      (out_immediate),
    .out_alloc_dest     (out_alloc_dest)
  );

  rvdec_decode_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_instruction     (in_instruction),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_format_class   (out_format_class),
    .out_major_opcode   (out_major_opcode),
    .out_minor_function (out_minor_function),
    .out_upper_function (out_upper_function),
    .out_dest_reg       (out_dest_reg),
    .out_src_reg_a      (out_src_reg_a),
    .out_src_reg_b      (out_src_reg_b),
    .out_immediate      (out_immediate),
    .out_alloc_dest     (out_alloc_dest),
    .mismatch_count     (mismatch_count),
    .pending_count      (pending_count)
  );

  always #1 clk = ~clk;

  // Result-side back-pressure. Every so often pick a new stall mode and hold it for a
  // stretch: always ready, mostly ready, or long stalls with rare ready pulses.
  int stall_mode = 0;
  int mode_cycles_left = 0;
  always @(posedge clk) begin
    if (mode_cycles_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_cycles_left <= $urandom_range(16, 96);
    end else begin
      mode_cycles_left <= mode_cycles_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Present one request and hold it until the decoder takes it. in_valid is only raised
  // here; lowering it is left to the gap logic, so it never toggles twice in one step.
  task automatic send_request(input logic [InstrWidth-1:0] word);
    in_valid <= 1'b1;
    in_instruction <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and idle for a number of cycles; zero keeps the burst going.
  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      in_instruction <= $urandom();
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off new requests until every decoded result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    logic [InstrWidth-1:0] word;
    logic [6:0]            op;
    int                    burst_left;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: short bursts so the corner words also meet back-pressure.
    foreach (DirectedWords[k]) begin
      send_request(DirectedWords[k]);
      idle_sender(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
    end
    drain_results();

    // Random part: mostly well-formed words with random content, some pure noise.
    burst_left = $urandom_range(1, 20);
    for (int n = 0; n < RandomRequests; n++) begin
      word = $urandom();
      if ($urandom_range(0, 3) != 0) begin
        op = KnownOps[$urandom_range(0, 8)];
        word[6:0] = op;
        // Bias funct7 toward the encodings that change the class.
        if ((op == OpRegAlu || op == OpImmAlu) && $urandom_range(0, 1)) begin
          case ($urandom_range(0, 2))
            0: word[31:25] = Funct7Zero;
            1: word[31:25] = Funct7MulDiv;
            default: word[31:25] = Funct7Alt;
          endcase
        end
        // Aim the immediate-ALU funct3 at the shift codes half the time.
        if (op == OpImmAlu && $urandom_range(0, 1))
          word[14:12] = $urandom_range(0, 1) ? Funct3Sll : Funct3Srx;
        // Exercise rd zero now and then for the allocation flag.
        if ($urandom_range(0, 7) == 0) word[11:7] = '0;
      end
      send_request(word);

      if (n % 125 == 124) begin
        drain_results();
        burst_left = $urandom_range(1, 20);
      end else if (--burst_left == 0) begin
        idle_sender($urandom_range(1, 8));
        burst_left = $urandom_range(1, 20);
      end
    end

    // Let the last results drain, then let the two register stages settle.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("rv32im_instruction_decoder: match");
    end else begin
      $display("rv32im_instruction_decoder: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (every request waiting out the longest
  // gap and the longest result stall).
  initial begin
    #400000;
    $display("rv32im_instruction_decoder: mismatch");
    $finish;
  end

endmodule

### rv32im_instruction_decoder.f
hdl/rvdec_pkg.sv
hdl/rvdec_decode.sv
hdl/rv32im_instruction_decoder.sv
tb/sv/rvdec_decode_checker.sv
tb/sv/rv32im_instruction_decoder_tb.sv
